>>> hw/rtl/rlb_pkg.sv
// rate limiter with blacklist: shared types, constants and helper functions
// used by rlb_ctrl, rlb_dp and ip_rate_limiter_blacklist_core
package rlb_pkg;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_RATE_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_BAN_SECONDS = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_ALLOW   = 2'd0;
  localparam logic [1:0] VERDICT_BLOCKED = 2'd1;
  localparam logic [1:0] VERDICT_NEW_BAN = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LIM,
    OP_BSCAN,
    OP_BEL,
    OP_BDEC,
    OP_SSCAN,
    OP_SHIT,
    OP_MCNT,
    OP_MLO,
    OP_MHI,
    OP_ACC,
    OP_SDEC,
    OP_SMISS,
    OP_EMIT
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic enable;
    logic ban_hit;
    logic ban_miss;
    logic ban_expired;
    logic seen_hit;
    logic seen_miss;
  } status_t;

  // elapsed time, zero when time runs backwards
  function automatic logic [62:0] elapsed(input logic [62:0] now, input logic [62:0] then_t);
    elapsed = (now >= then_t) ? (now - then_t) : 63'd0;
  endfunction

  // saturating counter increment
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

>>> hw/rtl/rlb_dp.sv
// rate limiter datapath: config registers, blacklist and seen tables,
// sequential scan, shared 32x32 multiplier and rate compare; uses rlb_pkg
module rlb_dp #(
  parameter int BAN_ENTRIES  = 16,
  parameter int SEEN_ENTRIES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [1:0]       cfg_index,
  input  logic [30:0]      cfg_wdata,
  input  logic [31:0]      client_addr,
  input  logic [62:0]      now_ns,
  input  rlb_pkg::op_t     op,
  output rlb_pkg::status_t status,
  output logic [1:0]       verdict
);
  import rlb_pkg::*;

  localparam int BW = $clog2(BAN_ENTRIES);
  localparam int SW = $clog2(SEEN_ENTRIES);
  localparam logic [BW-1:0] BAN_LAST = BW'(BAN_ENTRIES - 1);
  localparam logic [SW:0] SEEN_FULL = (SW + 1)'(SEEN_ENTRIES);
  localparam logic [SW-1:0] SEEN_LAST = SW'(SEEN_ENTRIES - 1);

  // configuration
  logic        enable;
  logic [30:0] rate_limit;
  logic [30:0] ban_seconds;

  // current item and result
  logic [31:0] addr_q;
  logic [62:0] now_q;
  logic [1:0]  res;

  // blacklist table
  logic [31:0]            ban_addr [BAN_ENTRIES];
  logic [31:0]            ban_count [BAN_ENTRIES];
  logic [62:0]            ban_time [BAN_ENTRIES];
  logic [BAN_ENTRIES-1:0] ban_valid;
  logic [BW-1:0]          ban_ptr;
  logic [BW-1:0]          ban_idx;
  logic [BW-1:0]          ban_idx_d;
  logic                   ban_pend;
  logic [31:0]            ban_raddr;
  logic [31:0]            ban_rcount;
  logic [62:0]            ban_rtime;

  // seen table, valid entries are those below the fill count
  logic [31:0]   seen_addr [SEEN_ENTRIES];
  logic [31:0]   seen_count [SEEN_ENTRIES];
  logic [62:0]   seen_time [SEEN_ENTRIES];
  logic [SW-1:0] seen_ptr;
  logic [SW:0]   seen_fill;
  logic [SW-1:0] seen_idx;
  logic [SW-1:0] seen_idx_d;
  logic          seen_pend;
  logic [31:0]   seen_raddr;
  logic [31:0]   seen_rcount;
  logic [62:0]   seen_rtime;

  // arithmetic
  logic [62:0] el;
  logic [31:0] cnt;
  logic [63:0] prod;
  logic [63:0] lhs;
  logic [94:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic        mul_en;
  logic [31:0] rl1;

  logic ban_hit, ban_miss, ban_rd, ban_more, ban_exp;
  logic seen_hit, seen_miss, seen_rd, seen_more, seen_last;
  logic over;

  // scan compare and stop logic
  assign ban_hit   = ban_pend && ban_valid[ban_idx_d] && (ban_raddr == addr_q);
  assign ban_miss  = ban_pend && !ban_hit && (ban_idx_d == BAN_LAST);
  assign ban_rd    = (op == OP_BSCAN) && !ban_hit;
  assign ban_more  = (ban_idx != BAN_LAST);
  assign ban_exp   = ({1'b0, el} > prod);

  assign seen_last = (({1'b0, seen_idx_d} + (SW + 1)'(1)) == seen_fill);
  assign seen_hit  = seen_pend && (seen_raddr == addr_q);
  assign seen_miss = (seen_fill == '0) || (seen_pend && !seen_hit && seen_last);
  assign seen_rd   = (op == OP_SSCAN) && !seen_hit && (seen_fill != '0);
  assign seen_more = (({1'b0, seen_idx} + (SW + 1)'(1)) < seen_fill);

  // rate test: floor(c*1e9/el) > r is c*1e9 >= (r+1)*el
  assign rl1  = {1'b0, rate_limit} + 32'd1;
  assign over = (el == '0) || ({31'b0, lhs} >= acc);

  assign status = '{enable: enable, ban_hit: ban_hit, ban_miss: ban_miss,
                    ban_expired: ban_exp, seen_hit: seen_hit, seen_miss: seen_miss};

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (op)
      OP_LIM: begin
        mul_a = {1'b0, ban_seconds};
        mul_b = NS_PER_SEC;
      end
      OP_MCNT: begin
        mul_a = cnt;
        mul_b = NS_PER_SEC;
      end
      OP_MLO: begin
        mul_a = rl1;
        mul_b = el[31:0];
      end
      OP_MHI: begin
        mul_a = rl1;
        mul_b = {1'b0, el[62:32]};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      rate_limit  <= '0;
      ban_seconds <= '0;
      ban_valid   <= '0;
      ban_ptr     <= '0;
      seen_ptr    <= '0;
      seen_fill   <= '0;
      ban_idx     <= '0;
      ban_idx_d   <= '0;
      ban_pend    <= 1'b0;
      seen_idx    <= '0;
      seen_idx_d  <= '0;
      seen_pend   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_ENABLE:      enable <= cfg_wdata[0];
          CFG_RATE_LIMIT:  rate_limit <= cfg_wdata;
          CFG_BAN_SECONDS: ban_seconds <= cfg_wdata;
          default: ;
        endcase
      end
      if (op == OP_LOAD) begin
        ban_idx   <= '0;
        ban_pend  <= 1'b0;
        seen_idx  <= '0;
        seen_pend <= 1'b0;
      end
      if (ban_rd) begin
        ban_idx_d <= ban_idx;
        ban_pend  <= 1'b1;
        if (ban_more) ban_idx <= ban_idx + BW'(1);
      end
      if (seen_rd) begin
        seen_idx_d <= seen_idx;
        seen_pend  <= 1'b1;
        if (seen_more) seen_idx <= seen_idx + SW'(1);
      end
      // expired blacklist entry is freed
      if (op == OP_BDEC && ban_exp) ban_valid[ban_idx_d] <= 1'b0;
      // new ban goes to the round-robin slot
      if (op == OP_SDEC && over) begin
        ban_valid[ban_ptr] <= 1'b1;
        ban_ptr <= (ban_ptr == BAN_LAST) ? '0 : ban_ptr + BW'(1);
      end
      if (op == OP_SMISS) begin
        seen_ptr <= (seen_ptr == SEEN_LAST) ? '0 : seen_ptr + SW'(1);
        if (seen_fill != SEEN_FULL) seen_fill <= seen_fill + (SW + 1)'(1);
      end
    end
  end

  // blacklist memory
  always_ff @(posedge clk) begin
    if (ban_rd) begin
      ban_raddr  <= ban_addr[ban_idx];
      ban_rcount <= ban_count[ban_idx];
      ban_rtime  <= ban_time[ban_idx];
    end
    if (op == OP_BDEC && !ban_exp) begin
      ban_count[ban_idx_d] <= sat_inc(ban_rcount);
      ban_time[ban_idx_d]  <= now_q;
    end
    if (op == OP_SDEC && over) begin
      ban_addr[ban_ptr]  <= addr_q;
      ban_count[ban_ptr] <= 32'd1;
      ban_time[ban_ptr]  <= now_q;
    end
  end

  // seen memory
  always_ff @(posedge clk) begin
    if (seen_rd) begin
      seen_raddr  <= seen_addr[seen_idx];
      seen_rcount <= seen_count[seen_idx];
      seen_rtime  <= seen_time[seen_idx];
    end
    if (op == OP_SHIT) seen_count[seen_idx_d] <= sat_inc(seen_rcount);
    if (op == OP_SDEC && !over) seen_time[seen_idx_d] <= now_q;
    if (op == OP_SMISS) begin
      seen_addr[seen_ptr]  <= addr_q;
      seen_count[seen_ptr] <= 32'd1;
      seen_time[seen_ptr]  <= now_q;
    end
  end

  // item, arithmetic and result registers
  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_p;
    case (op)
      OP_LOAD: begin
        addr_q <= client_addr;
        now_q  <= now_ns;
        res    <= VERDICT_ALLOW;
      end
      OP_BEL:  el <= elapsed(now_q, ban_rtime);
      OP_BDEC: if (!ban_exp) res <= VERDICT_BLOCKED;
      OP_SHIT: begin
        el  <= elapsed(now_q, seen_rtime);
        cnt <= sat_inc(seen_rcount);
      end
      OP_MLO:  lhs <= prod;
      OP_MHI:  acc <= {31'b0, prod};
      OP_ACC:  acc <= acc + {prod[62:0], 32'b0};
      OP_SDEC: if (over) res <= VERDICT_NEW_BAN;
      OP_EMIT: verdict <= res;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_scan_excl: assert property (@(posedge clk) disable iff (rst)
    !(ban_hit && ban_miss) && !(seen_hit && seen_miss))
    else $error("scan hit and miss at once");
  a_ban_slot: assert property (@(posedge clk) disable iff (rst)
    (op == OP_SDEC && over) |=> ban_valid[$past(ban_ptr)])
    else $error("new ban slot not valid");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    seen_fill <= SEEN_FULL)
    else $error("seen fill count overflow");
`endif

endmodule

>>> hw/rtl/rlb_ctrl.sv
// rate limiter controller: sequences lookups, arithmetic and the output
// register; drives rlb_dp through op codes from rlb_pkg
module rlb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rlb_pkg::status_t status,
  output rlb_pkg::op_t     op
);
  import rlb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LIM, S_BSCAN, S_BEL, S_BDEC, S_SSCAN, S_SHIT,
    S_MCNT, S_MLO, S_MHI, S_ACC, S_SDEC, S_SMISS, S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and datapath op
  always_comb begin
    state_next = state;
    op = OP_NONE;
    case (state)
      S_IDLE: if (in_valid) begin
        op = OP_LOAD;
        state_next = status.enable ? S_LIM : S_FIN;
      end
      S_LIM: begin
        op = OP_LIM;
        state_next = S_BSCAN;
      end
      S_BSCAN: begin
        op = OP_BSCAN;
        if (status.ban_hit) state_next = S_BEL;
        else if (status.ban_miss) state_next = S_SSCAN;
      end
      S_BEL: begin
        op = OP_BEL;
        state_next = S_BDEC;
      end
      S_BDEC: begin
        op = OP_BDEC;
        state_next = status.ban_expired ? S_SSCAN : S_FIN;
      end
      S_SSCAN: begin
        op = OP_SSCAN;
        if (status.seen_hit) state_next = S_SHIT;
        else if (status.seen_miss) state_next = S_SMISS;
      end
      S_SHIT: begin
        op = OP_SHIT;
        state_next = S_MCNT;
      end
      S_MCNT: begin
        op = OP_MCNT;
        state_next = S_MLO;
      end
      S_MLO: begin
        op = OP_MLO;
        state_next = S_MHI;
      end
      S_MHI: begin
        op = OP_MHI;
        state_next = S_ACC;
      end
      S_ACC: begin
        op = OP_ACC;
        state_next = S_SDEC;
      end
      S_SDEC: begin
        op = OP_SDEC;
        state_next = S_FIN;
      end
      S_SMISS: begin
        op = OP_SMISS;
        state_next = S_FIN;
      end
      S_FIN: if (out_free) begin
        op = OP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LIM || state == S_FIN))
    else $error("accepted item did not start work");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result shown outside finish");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |-> out_free)
    else $error("result overwritten while waiting");
`endif

endmodule

>>> hw/rtl/ip_rate_limiter_blacklist_core.sv
// Per-address request rate limiter with a blacklist.
// Input channel (in_valid/in_ready) takes one item: client_addr and now_ns.
// Output channel (out_valid/out_ready) gives one verdict per item:
//   0 allowed, 1 already blacklisted, 2 newly blacklisted.
// Config port: cfg_wen writes cfg_wdata to register cfg_index
//   (0 enable, 1 rate_limit, 2 ban_seconds); write only while idle.
// Steps: disabled, load and then finish. Enabled, load, ban limit, blacklist
//   scan, on a hit the expiry check (a live ban goes to finish), then the seen
//   scan and either the rate check or a new seen entry, then finish.
// Throughput: one item at a time; the cost is set by the sequential scan
// of the two single-port tables, one entry read per cycle.
// The rate check uses one shared 32x32 multiplier over its multiply steps.
// Reset clears config, table valid bits, fill count and slot pointers;
// no clearing pass is needed. The output register holds a verdict while
// out_ready is low; the next item is accepted meanwhile and waits in the
// finish step until the register frees.
module ip_rate_limiter_blacklist_core #(
  parameter int BAN_ENTRIES  = 16,
  parameter int SEEN_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] client_addr,
  input  logic [62:0] now_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict
);
  import rlb_pkg::*;

  op_t     op;
  status_t status;

  // sequencer
  rlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // tables and arithmetic
  rlb_dp #(
    .BAN_ENTRIES  (BAN_ENTRIES),
    .SEEN_ENTRIES (SEEN_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .client_addr (client_addr),
    .now_ns      (now_ns),
    .op          (op),
    .status      (status),
    .verdict     (verdict)
  );

endmodule

>>> sim/tb.sv
// testbench for ip_rate_limiter_blacklist_core: random and directed requests,
// verdicts checked against a cycle-free predictor held in a small scoreboard
// depends on rlb_pkg and the core rtl
module tb;
  import rlb_pkg::*;

  localparam int BAN_DEPTH  = 16;
  localparam int SEEN_DEPTH = 128;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned NS_SEC = 64'd1000000000;
  localparam logic [62:0] TIME_MAX = {63{1'b1}};
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT = 3000000;

  // rate limiter predictor plus queue of expected verdicts
  class verdict_board;
    bit               en;
    bit [30:0]        rate_lim;
    bit [30:0]        ban_sec;
    bit               bvalid [BAN_DEPTH];
    bit [31:0]        baddr [BAN_DEPTH];
    bit [31:0]        bcount [BAN_DEPTH];
    bit [62:0]        btime [BAN_DEPTH];
    bit               svalid [SEEN_DEPTH];
    bit [31:0]        saddr [SEEN_DEPTH];
    bit [31:0]        scount [SEEN_DEPTH];
    bit [62:0]        stime [SEEN_DEPTH];
    int               bslot;
    int               sslot;
    logic [1:0]       pending_verdicts [$];
    int               fails;

    function void clear();
      en = 0; rate_lim = 0; ban_sec = 0; bslot = 0; sslot = 0; fails = 0;
      foreach (bvalid[i]) bvalid[i] = 0;
      foreach (svalid[i]) svalid[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        CFG_ENABLE:      en = val[0];
        CFG_RATE_LIMIT:  rate_lim = val;
        CFG_BAN_SECONDS: ban_sec = val;
        default: ;
      endcase
    endfunction

    function bit [62:0] span(bit [62:0] now, bit [62:0] then_t);
      return (now >= then_t) ? now - then_t : 63'd0;
    endfunction

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // work out the verdict for one accepted item
    function void note_request(bit [31:0] a, bit [62:0] t);
      int at;
      bit over;
      bit [62:0] el;
      longint unsigned prod;
      at = -1;
      if (!en) begin
        pending_verdicts.push_back(VERDICT_ALLOW);
        return;
      end
      // blacklist lookup, lowest index wins
      for (int i = 0; i < BAN_DEPTH; i++)
        if (at < 0 && bvalid[i] && baddr[i] == a) at = i;
      if (at >= 0) begin
        if (64'(span(t, btime[at])) > longint'(ban_sec) * NS_SEC) begin
          bvalid[at] = 0;
        end else begin
          bcount[at] = bump(bcount[at]);
          btime[at] = t;
          pending_verdicts.push_back(VERDICT_BLOCKED);
          return;
        end
      end
      // seen table lookup
      at = -1;
      for (int i = 0; i < SEEN_DEPTH; i++)
        if (at < 0 && svalid[i] && saddr[i] == a) at = i;
      if (at >= 0) begin
        scount[at] = bump(scount[at]);
        el = span(t, stime[at]);
        if (el == 0) begin
          over = 1;
        end else begin
          prod = longint'(scount[at]) * NS_SEC;
          over = (prod / 64'(el)) > 64'(rate_lim);
        end
        if (over) begin
          bvalid[bslot] = 1; baddr[bslot] = a; bcount[bslot] = 1; btime[bslot] = t;
          bslot = (bslot + 1) % BAN_DEPTH;
          pending_verdicts.push_back(VERDICT_NEW_BAN);
        end else begin
          stime[at] = t;
          pending_verdicts.push_back(VERDICT_ALLOW);
        end
      end else begin
        svalid[sslot] = 1; saddr[sslot] = a; scount[sslot] = 1; stime[sslot] = t;
        sslot = (sslot + 1) % SEEN_DEPTH;
        pending_verdicts.push_back(VERDICT_ALLOW);
      end
    endfunction

    function void check_verdict(logic [1:0] v);
      logic [1:0] exp_v;
      if (pending_verdicts.size() == 0) begin
        $error("verdict: no item waiting, actual %0d", v);
        fails++;
        return;
      end
      exp_v = pending_verdicts.pop_front();
      if (v !== exp_v) begin
        $error("verdict: expected %0d actual %0d", exp_v, v);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] client_addr = '0;
  logic [62:0] now_ns = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  verdict;

  verdict_board board = new();
  int          cycles = 0;
  int          stall_mode = 0;
  logic [62:0] clock_ns = '0;
  logic [31:0] addr_pool [24];

  ip_rate_limiter_blacklist_core dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .client_addr(client_addr), .now_ns(now_ns), .out_valid(out_valid),
    .out_ready(out_ready), .verdict(verdict)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: out_ready follows a randomly chosen stall pattern, checks each verdict
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
    if (!rst && out_valid && out_ready) board.check_verdict(verdict);
    if (cycles >= CYCLE_LIMIT) begin
      $display("ip_rate_limiter_blacklist_core test failed");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [30:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.write_reg(idx, val);
  endtask

  // valid stays high after acceptance; the caller lowers it on a gap
  task automatic send_request(logic [31:0] a, logic [62:0] t);
    in_valid <= 1'b1;
    client_addr <= a;
    now_ns <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(a, t);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // pick the next request: mostly pool addresses with rising time
  task automatic random_request(int fresh_pct);
    logic [31:0] a;
    logic [62:0] t;
    int r;
    r = $urandom_range(0, 99);
    a = (r < fresh_pct) ? $urandom() : addr_pool[$urandom_range(0, 23)];
    r = $urandom_range(0, 99);
    if (r < 10) clock_ns = clock_ns;
    else if (r < 60) clock_ns = clock_ns + 63'($urandom_range(0, 50000000));
    else if (r < 95) clock_ns = clock_ns + 63'($urandom_range(0, 2000000000));
    else clock_ns = clock_ns + 63'($urandom_range(0, 2000000000)) * 4;
    t = clock_ns;
    // time running backwards now and then
    if ($urandom_range(0, 99) < 3) t = clock_ns - 63'($urandom_range(0, 1000000000));
    send_request(a, t);
  endtask

  initial begin
    logic [30:0] rates [7];
    logic [30:0] bans [5];
    int burst;
    board.clear();
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled: every request allowed
    write_cfg(CFG_ENABLE, 31'd0);
    write_cfg(CFG_UNUSED, 31'h7FFF_FFFF);
    send_request(32'h0000_0000, 63'd0);
    send_request(32'hFFFF_FFFF, TIME_MAX);
    wait_drained();

    // directed: miss, zero elapsed ban, hit, backwards time, expiry, extremes
    write_cfg(CFG_ENABLE, 31'd1);
    write_cfg(CFG_RATE_LIMIT, 31'd2);
    write_cfg(CFG_BAN_SECONDS, 31'd1);
    send_request(32'h0000_0000, 63'd0);
    send_request(32'h0000_0000, 63'd0);
    send_request(32'h0000_0000, 63'd5);
    send_request(32'h0000_0000, 63'd3);
    send_request(32'h0000_0000, 63'd1000000003);
    send_request(32'h0000_0000, 63'd2000000005);
    send_request(32'h0000_0000, 63'd9000000000);
    send_request(32'h1234_5678, 63'd9000000000);
    send_request(32'h1234_5678, 63'd19000000000);
    send_request(32'h1234_5678, 63'd20000000000);
    send_request(32'hFFFF_FFFF, TIME_MAX - 63'd10);
    send_request(32'hFFFF_FFFF, TIME_MAX);
    send_request(32'hFFFF_FFFF, TIME_MAX);
    send_request(32'hA5A5_5A5A, 63'h2AAA_AAAA_AAAA_AAAA);
    send_request(32'h5A5A_A5A5, 63'h5555_5555_5555_5555);
    wait_drained();
    write_cfg(CFG_RATE_LIMIT, 31'h7FFF_FFFF);
    write_cfg(CFG_BAN_SECONDS, 31'h7FFF_FFFF);
    send_request(32'hA5A5_5A5A, TIME_MAX);
    send_request(32'h5A5A_A5A5, 63'h5555_5555_5555_5556);
    send_request(32'hA5A5_5A5A, 63'd0);
    wait_drained();

    // random phases over several settings
    rates = '{31'd0, 31'd1, 31'd3, 31'd10, 31'd1000, 31'h7FFF_FFFF, 31'd0};
    bans = '{31'd0, 31'd1, 31'd2, 31'd30, 31'h7FFF_FFFF};
    clock_ns = 63'd1000;
    for (int ph = 0; ph < 12; ph++) begin
      rates[6] = 31'($urandom_range(0, 31'h7FFF_FFFF));
      write_cfg(CFG_ENABLE, (ph % 6 == 5) ? 31'd0 : 31'd1);
      write_cfg(CFG_RATE_LIMIT, rates[$urandom_range(0, 6)]);
      write_cfg(CFG_BAN_SECONDS, bans[$urandom_range(0, 4)]);
      if (ph == 9) clock_ns = TIME_MAX - 63'd400000000000;
      for (int n = 0; n < 155; n += burst) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) random_request((ph % 3 == 0) ? 40 : 15);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
      end
      wait_drained();
    end

    if (board.fails == 0 && board.pending_verdicts.size() == 0) begin
      $display("ip_rate_limiter_blacklist_core test passed");
    end else begin
      $display("ip_rate_limiter_blacklist_core test failed");
    end
    $finish;
  end

endmodule
